// ===== rtl/core/imu_htc_pkg.sv =====
// shared types, constants and the arctangent table of the heading turn controller
`timescale 1ns / 1ps
`default_nettype none
package imu_htc_pkg;

   // default build options
   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ANGLE_BITS_DEF   = 16;

   // datapath widths
   localparam int QUAT_W    = 16;
   localparam int PROD_W    = 32;
   localparam int SUM_W     = 33;
   localparam int VEC_W     = 38;
   localparam int PHASE_W   = 32;
   localparam int SHIFT_W   = 5;
   localparam int RATE_W    = 15;
   localparam int TURN_W    = 16;
   localparam int CSR_IDX_W = 4;
   localparam int CSR_DAT_W = 16;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_STOP_THRESHOLD = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TURN_RATE      = 4'd1;

   // register reset values
   localparam logic [TURN_W-1:0] STOP_THRESHOLD_RST = 16'd32246;
   localparam logic [RATE_W-1:0] TURN_RATE_RST      = 15'd2458;

   // unity in the q28 operand scale
   localparam logic signed [VEC_W-1:0] ONE_Q28 = 38'sd268435456;

   // pi in the phase accumulator
   localparam logic [PHASE_W-1:0] PHASE_PI = 32'h8000_0000;

   // request and response payloads
   typedef struct packed {
      logic signed [QUAT_W-1:0] quat_w;
      logic signed [QUAT_W-1:0] quat_x;
      logic signed [QUAT_W-1:0] quat_y;
      logic signed [QUAT_W-1:0] quat_z;
   } req_type;

   typedef struct packed {
      logic [RATE_W-1:0] angular_rate;
      logic              finished;
      logic [TURN_W-1:0] turned_angle;
   } rsp_type;

   // register file contents seen by the sequencer
   typedef struct packed {
      logic [TURN_W-1:0] stop_threshold;
      logic [RATE_W-1:0] turn_rate;
   } cfg_type;

   // product steps of the operand former
   typedef enum logic [1:0] {
      MAC_WZ,
      MAC_XY,
      MAC_YY,
      MAC_ZZ
   } mac_step_type;

   typedef struct packed {
      logic         mac_en;
      mac_step_type step;
      logic         form;
   } vec_ctrl_type;

   typedef struct packed {
      logic               load;
      logic               rotate;
      logic [SHIFT_W-1:0] shift;
   } cordic_ctrl_type;

   // atan(2^-i) as a 32-bit binary angle, rounded to nearest
   function automatic logic [PHASE_W-1:0] atan_lookup(input logic [SHIFT_W-1:0] i);
      logic [PHASE_W-1:0] a;
      case (i)
         5'd0:    a = 32'd536870912;
         5'd1:    a = 32'd316933406;
         5'd2:    a = 32'd167458907;
         5'd3:    a = 32'd85004756;
         5'd4:    a = 32'd42667331;
         5'd5:    a = 32'd21354465;
         5'd6:    a = 32'd10679838;
         5'd7:    a = 32'd5340245;
         5'd8:    a = 32'd2670163;
         5'd9:    a = 32'd1335087;
         5'd10:   a = 32'd667544;
         5'd11:   a = 32'd333772;
         5'd12:   a = 32'd166886;
         5'd13:   a = 32'd83443;
         5'd14:   a = 32'd41722;
         5'd15:   a = 32'd20861;
         5'd16:   a = 32'd10430;
         5'd17:   a = 32'd5215;
         5'd18:   a = 32'd2608;
         5'd19:   a = 32'd1304;
         5'd20:   a = 32'd652;
         5'd21:   a = 32'd326;
         5'd22:   a = 32'd163;
         5'd23:   a = 32'd81;
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/imu_htc_csr.sv =====
// configuration registers: stop threshold and turn rate
`timescale 1ns / 1ps
`default_nettype none
module imu_htc_csr (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [imu_htc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [imu_htc_pkg::CSR_DAT_W-1:0]     csr_wdata,
   output imu_htc_pkg::cfg_type                  cfg
);

   logic [imu_htc_pkg::TURN_W-1:0] stop_threshold_ff;
   logic [imu_htc_pkg::TURN_W-1:0] stop_threshold_in;
   logic [imu_htc_pkg::RATE_W-1:0] turn_rate_ff;
   logic [imu_htc_pkg::RATE_W-1:0] turn_rate_in;

   // writes are always taken
   assign csr_ready = 1'b1;

   // address decode, unknown indexes are dropped
   always_comb begin
      stop_threshold_in = stop_threshold_ff;
      turn_rate_in      = turn_rate_ff;
      if (csr_valid) begin
         case (csr_index)
            imu_htc_pkg::CSR_STOP_THRESHOLD: begin
               stop_threshold_in = csr_wdata[imu_htc_pkg::TURN_W-1:0];
            end
            imu_htc_pkg::CSR_TURN_RATE: begin
               turn_rate_in = csr_wdata[imu_htc_pkg::RATE_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_threshold_ff <= imu_htc_pkg::STOP_THRESHOLD_RST;
         turn_rate_ff      <= imu_htc_pkg::TURN_RATE_RST;
      end else begin
         stop_threshold_ff <= stop_threshold_in;
         turn_rate_ff      <= turn_rate_in;
      end
   end

   assign cfg.stop_threshold = stop_threshold_ff;
   assign cfg.turn_rate      = turn_rate_ff;

endmodule
`default_nettype wire

// ===== rtl/core/imu_htc_vec.sv =====
// atan2 operand former: one shared multiply-accumulate over four product steps
`timescale 1ns / 1ps
`default_nettype none
module imu_htc_vec (
   input  wire                                      clock,
   input  wire  imu_htc_pkg::req_type               quat,
   input  wire  imu_htc_pkg::vec_ctrl_type          ctrl,
   output logic signed [imu_htc_pkg::VEC_W-1:0]     vec_x,
   output logic signed [imu_htc_pkg::VEC_W-1:0]     vec_y
);

   logic signed [imu_htc_pkg::QUAT_W-1:0] mul_a;
   logic signed [imu_htc_pkg::QUAT_W-1:0] mul_b;
   logic signed [imu_htc_pkg::PROD_W-1:0] prod;
   logic signed [imu_htc_pkg::SUM_W-1:0]  sum_y_ff;
   logic signed [imu_htc_pkg::SUM_W-1:0]  sum_y_in;
   logic signed [imu_htc_pkg::SUM_W-1:0]  sum_x_ff;
   logic signed [imu_htc_pkg::SUM_W-1:0]  sum_x_in;
   logic signed [imu_htc_pkg::VEC_W-1:0]  vec_x_ff;
   logic signed [imu_htc_pkg::VEC_W-1:0]  vec_x_in;
   logic signed [imu_htc_pkg::VEC_W-1:0]  vec_y_ff;
   logic signed [imu_htc_pkg::VEC_W-1:0]  vec_y_in;

   // operand select for the product step
   always_comb begin
      case (ctrl.step)
         imu_htc_pkg::MAC_WZ: begin
            mul_a = quat.quat_w;
            mul_b = quat.quat_z;
         end
         imu_htc_pkg::MAC_XY: begin
            mul_a = quat.quat_x;
            mul_b = quat.quat_y;
         end
         imu_htc_pkg::MAC_YY: begin
            mul_a = quat.quat_y;
            mul_b = quat.quat_y;
         end
         imu_htc_pkg::MAC_ZZ: begin
            mul_a = quat.quat_z;
            mul_b = quat.quat_z;
         end
         default: begin
            mul_a = quat.quat_w;
            mul_b = quat.quat_z;
         end
      endcase
   end

   assign prod = mul_a * mul_b;

   // accumulate wz+xy and y^2+z^2
   always_comb begin
      sum_y_in = sum_y_ff;
      sum_x_in = sum_x_ff;
      if (ctrl.mac_en) begin
         case (ctrl.step)
            imu_htc_pkg::MAC_WZ: sum_y_in = imu_htc_pkg::SUM_W'(prod);
            imu_htc_pkg::MAC_XY: sum_y_in = sum_y_ff + imu_htc_pkg::SUM_W'(prod);
            imu_htc_pkg::MAC_YY: sum_x_in = imu_htc_pkg::SUM_W'(prod);
            imu_htc_pkg::MAC_ZZ: sum_x_in = sum_x_ff + imu_htc_pkg::SUM_W'(prod);
            default: begin
            end
         endcase
      end
   end

   // scale to q28: y = 2(wz+xy), x = 1 - 2(y^2+z^2)
   always_comb begin
      vec_x_in = vec_x_ff;
      vec_y_in = vec_y_ff;
      if (ctrl.form) begin
         vec_y_in = imu_htc_pkg::VEC_W'(sum_y_ff) <<< 1;
         vec_x_in = imu_htc_pkg::ONE_Q28 - (imu_htc_pkg::VEC_W'(sum_x_ff) <<< 1);
      end
   end

   always_ff @(posedge clock) begin
      sum_y_ff <= sum_y_in;
      sum_x_ff <= sum_x_in;
      vec_x_ff <= vec_x_in;
      vec_y_ff <= vec_y_in;
   end

   assign vec_x = vec_x_ff;
   assign vec_y = vec_y_ff;

endmodule
`default_nettype wire

// ===== rtl/core/imu_htc_cordic.sv =====
// vectoring cordic rotator, one micro-rotation per cycle while rotate is set
`timescale 1ns / 1ps
`default_nettype none
module imu_htc_cordic (
   input  wire                                      clock,
   input  wire  imu_htc_pkg::cordic_ctrl_type       ctrl,
   input  wire  signed [imu_htc_pkg::VEC_W-1:0]     vec_x,
   input  wire  signed [imu_htc_pkg::VEC_W-1:0]     vec_y,
   output logic        [imu_htc_pkg::PHASE_W-1:0]   phase
);

   logic signed [imu_htc_pkg::VEC_W-1:0]   x_ff;
   logic signed [imu_htc_pkg::VEC_W-1:0]   x_in;
   logic signed [imu_htc_pkg::VEC_W-1:0]   y_ff;
   logic signed [imu_htc_pkg::VEC_W-1:0]   y_in;
   logic        [imu_htc_pkg::PHASE_W-1:0] phase_ff;
   logic        [imu_htc_pkg::PHASE_W-1:0] phase_in;
   logic signed [imu_htc_pkg::VEC_W-1:0]   dx;
   logic signed [imu_htc_pkg::VEC_W-1:0]   dy;
   logic        [imu_htc_pkg::PHASE_W-1:0] step_angle;
   logic                                   y_pos;

   // arithmetic shifts floor toward minus infinity
   assign dx         = y_ff >>> ctrl.shift;
   assign dy         = x_ff >>> ctrl.shift;
   assign step_angle = imu_htc_pkg::atan_lookup(ctrl.shift);
   assign y_pos      = !y_ff[imu_htc_pkg::VEC_W-1] && (y_ff != '0);

   always_comb begin
      x_in     = x_ff;
      y_in     = y_ff;
      phase_in = phase_ff;
      if (ctrl.load) begin
         // left half plane: turn by pi first
         if (vec_x[imu_htc_pkg::VEC_W-1]) begin
            x_in     = -vec_x;
            y_in     = -vec_y;
            phase_in = imu_htc_pkg::PHASE_PI;
         end else begin
            x_in     = vec_x;
            y_in     = vec_y;
            phase_in = '0;
         end
      end else if (ctrl.rotate) begin
         // drive y toward zero
         if (y_pos) begin
            x_in     = x_ff + dx;
            y_in     = y_ff - dy;
            phase_in = phase_ff + step_angle;
         end else begin
            x_in     = x_ff - dx;
            y_in     = y_ff + dy;
            phase_in = phase_ff - step_angle;
         end
      end
   end

   always_ff @(posedge clock) begin
      x_ff     <= x_in;
      y_ff     <= y_in;
      phase_ff <= phase_in;
   end

   assign phase = phase_ff;

endmodule
`default_nettype wire

// ===== rtl/core/imu_heading_turn_controller.sv =====
// heading turn controller top level: sequencer, heading state and response register
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+--------------------------------------
//   req     | in        | req_valid / req_ready  | req_data  (quat_w, quat_x, quat_y, quat_z)
//   rsp     | out       | rsp_valid / rsp_ready  | rsp_data  (angular_rate, finished, turned_angle)
//   csr     | in        | csr_valid / csr_ready  | csr_index, csr_wdata
//
// a request passes through four multiply-accumulate steps, one scaling, one load,
// CORDIC_STEPS rotations, one rounding and one decision before its registered response;
// the first request after reset only records the start heading and gives no response.
// once the turn is complete a request is still taken and produces no response.
// reset is synchronous and clears the start heading, the completion flag and rsp_valid.
// the decision cycle waits while an earlier response is still untaken; the next
// request is accepted as soon as the decision is done.
`timescale 1ns / 1ps
`default_nettype none
module imu_heading_turn_controller #(
   parameter int CORDIC_STEPS = imu_htc_pkg::CORDIC_STEPS_DEF,
   parameter int ANGLE_BITS   = imu_htc_pkg::ANGLE_BITS_DEF
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   req_valid,
   output logic                                  req_ready,
   input  wire  imu_htc_pkg::req_type            req_data,
   output logic                                  rsp_valid,
   input  wire                                   rsp_ready,
   output imu_htc_pkg::rsp_type                  rsp_data,
   input  wire                                   csr_valid,
   output logic                                  csr_ready,
   input  wire  [imu_htc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire  [imu_htc_pkg::CSR_DAT_W-1:0]     csr_wdata
);

   localparam int STEP_W = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);
   localparam logic [imu_htc_pkg::PHASE_W-1:0] ROUND_HALF =
      imu_htc_pkg::PHASE_W'(64'd1 << (31 - ANGLE_BITS));

   typedef enum logic [2:0] {
      S_IDLE,
      S_MUL,
      S_FORM,
      S_LOAD,
      S_ITER,
      S_ROUND,
      S_DECIDE
   } state_type;

   state_type                           state_ff;
   state_type                           state_in;
   imu_htc_pkg::mac_step_type           mac_step_ff;
   imu_htc_pkg::mac_step_type           mac_step_in;
   logic [STEP_W-1:0]                   iter_ff;
   logic [STEP_W-1:0]                   iter_in;
   imu_htc_pkg::req_type                quat_ff;
   imu_htc_pkg::req_type                quat_in;
   logic                                zero_ff;
   logic                                zero_in;
   logic [ANGLE_BITS-1:0]               yaw_ff;
   logic [ANGLE_BITS-1:0]               yaw_in;
   logic [ANGLE_BITS-1:0]               start_ff;
   logic [ANGLE_BITS-1:0]               start_in;
   logic                                have_start_ff;
   logic                                have_start_in;
   logic                                complete_ff;
   logic                                complete_in;
   logic                                rsp_valid_ff;
   logic                                rsp_valid_in;
   imu_htc_pkg::rsp_type                rsp_ff;
   imu_htc_pkg::rsp_type                rsp_in;

   imu_htc_pkg::cfg_type                cfg;
   imu_htc_pkg::vec_ctrl_type           vec_ctrl;
   imu_htc_pkg::cordic_ctrl_type        cordic_ctrl;
   logic signed [imu_htc_pkg::VEC_W-1:0] vec_x;
   logic signed [imu_htc_pkg::VEC_W-1:0] vec_y;
   logic [imu_htc_pkg::PHASE_W-1:0]     phase;
   logic [imu_htc_pkg::PHASE_W-1:0]     phase_rnd;
   logic [ANGLE_BITS-1:0]               diff;
   logic [ANGLE_BITS-1:0]               turned;
   logic [ANGLE_BITS+15:0]              turned_wide;
   logic [imu_htc_pkg::TURN_W-1:0]      turned16;
   logic                                slot_free;

   imu_htc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   imu_htc_vec u_vec (
      .clock (clock),
      .quat  (quat_ff),
      .ctrl  (vec_ctrl),
      .vec_x (vec_x),
      .vec_y (vec_y)
   );

   imu_htc_cordic u_cordic (
      .clock (clock),
      .ctrl  (cordic_ctrl),
      .vec_x (vec_x),
      .vec_y (vec_y),
      .phase (phase)
   );

   // unit control decoded from the state
   assign vec_ctrl.mac_en     = (state_ff == S_MUL);
   assign vec_ctrl.step       = mac_step_ff;
   assign vec_ctrl.form       = (state_ff == S_FORM);
   assign cordic_ctrl.load    = (state_ff == S_LOAD);
   assign cordic_ctrl.rotate  = (state_ff == S_ITER);
   assign cordic_ctrl.shift   = imu_htc_pkg::SHIFT_W'(iter_ff);

   // yaw rounded to nearest, ties up
   assign phase_rnd = phase + ROUND_HALF;

   // heading difference wraps; exactly pi stays pi under negation
   assign diff        = yaw_ff - start_ff;
   assign turned      = diff[ANGLE_BITS-1] ? (~diff + 1'b1) : diff;
   assign turned_wide = {turned, 16'b0} >> ANGLE_BITS;
   assign turned16    = turned_wide[imu_htc_pkg::TURN_W-1:0];

   assign slot_free = !rsp_valid_ff || rsp_ready;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      mac_step_in   = mac_step_ff;
      iter_in       = iter_ff;
      quat_in       = quat_ff;
      zero_in       = zero_ff;
      yaw_in        = yaw_ff;
      start_in      = start_ff;
      have_start_in = have_start_ff;
      complete_in   = complete_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_in        = rsp_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !complete_ff) begin
               quat_in     = req_data;
               mac_step_in = imu_htc_pkg::MAC_WZ;
               state_in    = S_MUL;
            end
         end
         S_MUL: begin
            case (mac_step_ff)
               imu_htc_pkg::MAC_WZ: mac_step_in = imu_htc_pkg::MAC_XY;
               imu_htc_pkg::MAC_XY: mac_step_in = imu_htc_pkg::MAC_YY;
               imu_htc_pkg::MAC_YY: mac_step_in = imu_htc_pkg::MAC_ZZ;
               default: begin
                  mac_step_in = imu_htc_pkg::MAC_WZ;
                  state_in    = S_FORM;
               end
            endcase
         end
         S_FORM: begin
            state_in = S_LOAD;
         end
         S_LOAD: begin
            zero_in  = (vec_x == '0) && (vec_y == '0);
            iter_in  = '0;
            state_in = S_ITER;
         end
         S_ITER: begin
            if (iter_ff == LAST_STEP) begin
               state_in = S_ROUND;
            end else begin
               iter_in = iter_ff + 1'b1;
            end
         end
         S_ROUND: begin
            yaw_in   = zero_ff ? '0 : phase_rnd[imu_htc_pkg::PHASE_W-1 -: ANGLE_BITS];
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (!have_start_ff) begin
               start_in      = yaw_ff;
               have_start_in = 1'b1;
               state_in      = S_IDLE;
            end else if (slot_free) begin
               rsp_valid_in        = 1'b1;
               rsp_in.turned_angle = turned16;
               if (turned16 < cfg.stop_threshold) begin
                  rsp_in.angular_rate = cfg.turn_rate;
                  rsp_in.finished     = 1'b0;
               end else begin
                  rsp_in.angular_rate = '0;
                  rsp_in.finished     = 1'b1;
                  complete_in         = 1'b1;
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         mac_step_ff   <= imu_htc_pkg::MAC_WZ;
         iter_ff       <= '0;
         start_ff      <= '0;
         have_start_ff <= 1'b0;
         complete_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mac_step_ff   <= mac_step_in;
         iter_ff       <= iter_in;
         start_ff      <= start_in;
         have_start_ff <= have_start_in;
         complete_ff   <= complete_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      quat_ff <= quat_in;
      zero_ff <= zero_in;
      yaw_ff  <= yaw_in;
      rsp_ff  <= rsp_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

// ===== rtl/core/imu_htc_checker.sv =====
// port-level checks of the heading turn controller and their binding
`timescale 1ns / 1ps
`default_nettype none
module imu_htc_checker (
   input wire                       clock,
   input wire                       reset,
   input wire                       req_ready,
   input wire                       rsp_valid,
   input wire                       rsp_ready,
   input wire imu_htc_pkg::rsp_type rsp_data
);

   logic fin_seen_ff;
   logic fin_seen_in;

   // remember a delivered stop response
   assign fin_seen_in = fin_seen_ff || (rsp_valid && rsp_ready && rsp_data.finished);

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_seen_ff <= 1'b0;
      end else begin
         fin_seen_ff <= fin_seen_in;
      end
   end

   // a stalled response holds
   rsp_hold_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // the stop response commands zero rate
   stop_rate_a: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.finished |-> rsp_data.angular_rate == '0)
      else $error("stop response with non-zero rate");

   // nothing follows the stop response
   silent_a: assert property (@(posedge clock) disable iff (reset)
      fin_seen_ff |-> !rsp_valid)
      else $error("response after the turn completed");

   // a fresh response only comes out of a busy sequencer
   busy_a: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response raised while the sequencer was idle");

endmodule

bind imu_heading_turn_controller imu_htc_checker u_imu_htc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
`default_nettype wire
